### src/m2cv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2cv_pkg
// Types and constants shared by the front and back parts of the MIDI to CV
// highest-note tracker.
// ----------------------------------------------------------------------------
package m2cv_pkg;

	localparam int NOTE_W = 7;
	localparam int CV_W   = 13;

	// Status byte high nibbles that the tracker acts on.
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

	// Action codes of an input item.
	localparam logic ACT_MESSAGE = 1'b0;
	localparam logic ACT_POLL    = 1'b1;

	// Pitch voltage: (note - 21) * 64 / 3 in Q.8. The division by three is a
	// multiply by ceil(2^16 / 3) and a shift, exact for magnitudes below 2^13.
	localparam logic [NOTE_W-1:0] LOWEST_PITCH_KEY = 7'd21;
	localparam int                MAG_W            = 13;
	localparam int                RECIP_W          = 15;
	localparam logic [RECIP_W-1:0] RECIP3          = 15'd21846;
	localparam int                RECIP_SHIFT      = 16;
	localparam int                PROD_W           = MAG_W + RECIP_W;
	localparam int                QUOT_W           = PROD_W - RECIP_SHIFT;

	// Command queue between the front and back parts.
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_POLL    = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [NOTE_W-1:0] key;
	} cmd_t;

endpackage

### src/m2cv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2cv_front
// Accepts input items, decodes them into key commands or polls, drops the
// ones that do nothing, and queues the rest for the back part.
// ----------------------------------------------------------------------------
module m2cv_front #(
	parameter int NUM_KEYS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [7:0]           status,
	input  logic [6:0]           data1,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output m2cv_pkg::cmd_t       cmd
);
	import m2cv_pkg::*;

	cmd_t                cmd_mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;

	cmd_t  dec_cmd;
	logic  dec_keep;
	logic  key_ok;
	logic  enq;
	logic  deq;

	assign key_ok = ({1'b0, data1} < 8'(NUM_KEYS));

	always_comb begin
		dec_cmd.key = data1;
		dec_cmd.op  = OP_POLL;
		dec_keep    = 1'b0;
		if (action == ACT_POLL) begin
			dec_keep = 1'b1;
		end else begin
			unique case (status[7:4])
				KIND_NOTE_ON: begin
					dec_cmd.op = OP_PRESS;
					dec_keep   = key_ok;
				end
				KIND_NOTE_OFF: begin
					dec_cmd.op = OP_RELEASE;
					dec_keep   = key_ok;
				end
				default: begin
					dec_keep = 1'b0;
				end
			endcase
		end
	end

	assign full      = (count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = cmd_mem_q[rd_ptr_q];
	assign enq       = push && !full && dec_keep;
	assign deq       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (enq) begin
			cmd_mem_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
		else $error("command queue count beyond its depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(enq && !deq) |=> (count_q == $past(count_q) + 1'b1))
		else $error("command queue count missed a write");
`endif

endmodule

### src/m2cv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2cv_back
// Carries out queued commands: keeps the key map, the held note and the
// pending trigger, scans for the highest key on a poll, converts the note to
// a pitch voltage and holds the result in an output register.
// ----------------------------------------------------------------------------
module m2cv_back #(
	parameter int NUM_KEYS = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  m2cv_pkg::cmd_t                     cmd,
	output logic                               empty,
	input  logic                               pop,
	output logic [m2cv_pkg::NOTE_W-1:0]        note,
	output logic signed [m2cv_pkg::CV_W-1:0]   cv_q8,
	output logic                               gate,
	output logic                               trig
);
	import m2cv_pkg::*;

	localparam int KW = $clog2(NUM_KEYS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MULT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [NUM_KEYS-1:0]  key_q;
	logic [KW-1:0]        idx_q;
	logic [NOTE_W-1:0]    held_q;
	logic                 any_q;
	logic                 trig_q;
	logic                 neg_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 out_valid_q;

	logic [KW-1:0]        cmd_key;
	logic                 neg;
	logic [NOTE_W-1:0]    key_offset;
	logic [MAG_W-1:0]     mag;
	logic [QUOT_W-1:0]    quot;
	logic [CV_W-1:0]      cv_next;
	logic                 load;

	assign cmd_key   = cmd.key[KW-1:0];
	assign cmd_ready = (state_q == ST_IDLE);

	// Distance from the lowest pitch key, scaled by 64.
	assign neg        = (held_q < LOWEST_PITCH_KEY);
	assign key_offset = neg ? (LOWEST_PITCH_KEY - held_q) : (held_q - LOWEST_PITCH_KEY);
	assign mag        = {key_offset, 6'd0};

	assign quot    = prod_q[PROD_W-1:RECIP_SHIFT];
	assign cv_next = neg_q ? CV_W'(-{1'b0, quot}) : CV_W'({1'b0, quot});

	assign load  = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			prod_q <= mag * RECIP3;
			neg_q  <= neg;
		end
		if (load) begin
			note  <= held_q;
			cv_q8 <= cv_next;
			gate  <= any_q;
			trig  <= trig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '0;
			idx_q       <= '0;
			held_q      <= '0;
			any_q       <= 1'b0;
			trig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_PRESS: begin
								if (!key_q[cmd_key]) begin
									trig_q <= 1'b1;
								end
								key_q[cmd_key] <= 1'b1;
							end
							OP_RELEASE: begin
								key_q[cmd_key] <= 1'b0;
							end
							OP_POLL: begin
								idx_q   <= KW'(NUM_KEYS - 1);
								any_q   <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (key_q[idx_q]) begin
						held_q  <= NOTE_W'(idx_q);
						any_q   <= 1'b1;
						state_q <= ST_MULT;
					end else if (idx_q == '0) begin
						state_q <= ST_MULT;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_MULT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load) begin
						trig_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_trig_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (!trig_q && !empty && (state_q == ST_IDLE)))
		else $error("trigger not cleared after a poll result was loaded");

	a_found_key: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && key_q[idx_q])
		|=> ((state_q == ST_MULT) && any_q && (held_q == NOTE_W'($past(idx_q)))))
		else $error("scan hit did not capture the key");

	a_press_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ready && cmd_valid && (cmd.op == OP_PRESS) && !key_q[cmd_key])
		|=> trig_q)
		else $error("new key press did not arm the trigger");

	a_scan_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && !key_q[idx_q] && (idx_q == '0))
		|=> ((state_q == ST_MULT) && !any_q))
		else $error("empty scan reported a pressed key");
`endif

endmodule

### src/midi_to_cv_highest_note.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_to_cv_highest_note
// MIDI note tracker with highest-note priority and pitch voltage output.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave
// through another (empty/pop). An item is either a MIDI channel message or a
// poll. Note-on (status high nibble 9) presses the key in data1 and arms the
// trigger if that key was up; note-off (high nibble 8) releases it; other
// message kinds, the channel nibble, data2 and key numbers at or above
// NUM_KEYS are ignored, and a message gives no result. A poll gives one
// result: the highest pressed key (or the last held note if none is pressed),
// its pitch voltage (note - 21) / 12 V as signed Q.8 truncated toward zero,
// the gate (any key pressed) and the trigger, which the poll then clears.
// Items pass a four-entry command queue, so until it is full the input keeps
// taking items while a poll is being worked on or its result waits to be
// popped. In the back part a message is carried out in the idle state; a
// poll is issued, the key map is scanned downward one key per cycle (1 to
// NUM_KEYS keys, stopping at the first pressed key), the reciprocal multiply
// runs and the output register is loaded once it is empty or being popped.
// The scan and that wait set the poll time. Control state resets
// asynchronously: every key released, held note zero and no pending trigger.
// ----------------------------------------------------------------------------
module midi_to_cv_highest_note #(
	parameter int NUM_KEYS = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               action,
	input  logic [7:0]                         status,
	input  logic [6:0]                         data1,
	input  logic [6:0]                         data2,
	output logic                               empty,
	input  logic                               pop,
	output logic [m2cv_pkg::NOTE_W-1:0]        note,
	output logic signed [m2cv_pkg::CV_W-1:0]   cv_q8,
	output logic                               gate,
	output logic                               trig
);
	import m2cv_pkg::*;

	// Velocity is carried on the port but never examined.
	logic   cmd_valid;
	logic   cmd_ready;
	cmd_t   cmd;

	m2cv_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.status    (status),
		.data1     (data1),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	m2cv_back #(
		.NUM_KEYS (NUM_KEYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.note      (note),
		.cv_q8     (cv_q8),
		.gate      (gate),
		.trig      (trig)
	);

endmodule
